// File: rtl/core/swsr_pkg.sv
// Shared constants, types and codes for the strided window stretch receptor.
// No dependencies; imported by every module of the block.
package swsr_pkg;

	// frame and window geometry
	localparam int SEGMENTS   = 50;
	localparam int UNITS      = 10;
	localparam int WINDOW     = 6;
	localparam int STRIDE     = 4;
	localparam int STRIDE_LOG = 2;
	localparam int B_OFFSET   = 12;

	// segment positions (1-based) of the first and last window end per class
	localparam int A_FIRST = WINDOW;
	localparam int A_LAST  = WINDOW + STRIDE * (UNITS - 2);
	localparam int B_FIRST = B_OFFSET + WINDOW;
	localparam int B_LAST  = B_FIRST + STRIDE * (UNITS - 2);

	// field widths
	localparam int LEN_W  = 16;
	localparam int GAIN_W = 16;
	localparam int SUM_W  = 19;
	localparam int UNIT_W = 4;
	localparam int CNT_W  = 6;
	localparam int RESP_W = 32;

	// configuration register map
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_A_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_B_GAIN = 2'd1;
	localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd256;

	// floor(x / 6) = (x * RECIP_SIX) >> RECIP_SHIFT, exact for x < 2^21
	localparam int               RECIP_SHIFT = 22;
	localparam int               RECIP_W     = 20;
	localparam logic [RECIP_W-1:0] RECIP_SIX = 20'd699051;
	localparam int               ROUND_BIAS  = WINDOW / 2;

	// job queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef enum logic {
		CLASS_A = 1'b0,
		CLASS_B = 1'b1
	} rclass_t;

	typedef struct packed {
		rclass_t            cls;
		logic [UNIT_W-1:0]  unit;
		logic               last;
	} meta_t;

	typedef struct packed {
		meta_t              meta;
		logic [SUM_W-1:0]   dsum;
		logic [SUM_W-1:0]   vsum;
		logic [GAIN_W-1:0]  gain;
	} job_t;

	// up to two jobs written per transfer; n is the number of valid jobs
	typedef struct packed {
		logic [1:0] n;
		job_t       job0;
		job_t       job1;
	} push_t;

	typedef struct packed {
		logic empty;
		logic room2;
	} qstat_t;

endpackage

// File: rtl/core/swsr_front.sv
// Front end: gain registers, segment delay lines, running sums and window classification.
// Depends on swsr_pkg; feeds swsr_queue with up to two jobs per segment.
module swsr_front import swsr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [GAIN_W-1:0]     wr_data,
	input  logic                  seg_valid,
	output logic                  seg_stall,
	input  logic [LEN_W-1:0]      dorsal_length,
	input  logic [LEN_W-1:0]      ventral_length,
	input  qstat_t                qstat,
	output push_t                 push
);

	logic [GAIN_W-1:0] a_gain_q, b_gain_q;
	logic [LEN_W-1:0]  dwin_q [WINDOW];
	logic [LEN_W-1:0]  vwin_q [WINDOW];
	logic [SUM_W-1:0]  dsum_q, vsum_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              accept;
	logic [SUM_W-1:0]  dsum_new, vsum_new;
	logic [CNT_W-1:0]  s;
	logic              a_hit, b_hit;
	logic [UNIT_W-1:0] u_a, u_b;

	function automatic job_t mk_job(input rclass_t cls, input logic [UNIT_W-1:0] unit,
			input logic last, input logic [GAIN_W-1:0] gain,
			input logic [SUM_W-1:0] dsum, input logic [SUM_W-1:0] vsum);
		job_t j;
		j.meta.cls  = cls;
		j.meta.unit = unit;
		j.meta.last = last;
		j.dsum      = dsum;
		j.vsum      = vsum;
		j.gain      = gain;
		return j;
	endfunction

	assign seg_stall = !qstat.room2;
	assign accept    = seg_valid && qstat.room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_gain_q <= GAIN_RESET;
			b_gain_q <= GAIN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_A_GAIN: a_gain_q <= wr_data;
				CFG_B_GAIN: b_gain_q <= wr_data;
				default: ;
			endcase
		end
	end

	// running sums: add the new length, drop the one falling off the window
	assign dsum_new = dsum_q + SUM_W'(dorsal_length) - SUM_W'(dwin_q[WINDOW-1]);
	assign vsum_new = vsum_q + SUM_W'(ventral_length) - SUM_W'(vwin_q[WINDOW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				dwin_q[i] <= '0;
				vwin_q[i] <= '0;
			end
			dsum_q <= '0;
			vsum_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			dwin_q[0] <= dorsal_length;
			vwin_q[0] <= ventral_length;
			for (int i = 1; i < WINDOW; i++) begin
				dwin_q[i] <= dwin_q[i-1];
				vwin_q[i] <= vwin_q[i-1];
			end
			dsum_q <= dsum_new;
			vsum_q <= vsum_new;
			cnt_q  <= (cnt_q >= CNT_W'(SEGMENTS - 1)) ? '0 : cnt_q + CNT_W'(1);
		end
	end

	// s is the 1-based position of the newest segment in the frame
	assign s     = cnt_q + CNT_W'(1);
	assign a_hit = (s >= CNT_W'(A_FIRST)) && (s <= CNT_W'(A_LAST)) &&
	               (s[STRIDE_LOG-1:0] == STRIDE_LOG'(A_FIRST % STRIDE));
	assign b_hit = (s >= CNT_W'(B_FIRST)) && (s <= CNT_W'(B_LAST)) &&
	               (s[STRIDE_LOG-1:0] == STRIDE_LOG'(B_FIRST % STRIDE));
	assign u_a   = UNIT_W'((s - CNT_W'(A_FIRST)) >> STRIDE_LOG) + UNIT_W'(1);
	assign u_b   = UNIT_W'((s - CNT_W'(B_FIRST)) >> STRIDE_LOG);

	always_comb begin
		push      = '0;
		push.job0 = mk_job(CLASS_A, u_a, 1'b1, a_gain_q, dsum_new, vsum_new);
		push.job1 = mk_job(CLASS_B, u_b, 1'b1, b_gain_q, dsum_new, vsum_new);
		if (a_hit) begin
			if (s == CNT_W'(A_FIRST)) begin
				// head unit repeats the first class A unit, sent ahead of it
				push.job0 = mk_job(CLASS_A, '0, 1'b0, a_gain_q, dsum_new, vsum_new);
				push.job1 = mk_job(CLASS_A, u_a, 1'b1, a_gain_q, dsum_new, vsum_new);
				push.n    = 2'd2;
			end else if (b_hit) begin
				push.job0.meta.last = 1'b0;
				push.n              = 2'd2;
			end else begin
				push.n = 2'd1;
			end
		end else if (b_hit) begin
			push.job0 = mk_job(CLASS_B, u_b, 1'b1, b_gain_q, dsum_new, vsum_new);
			if (s == CNT_W'(B_LAST)) begin
				// tail unit repeats the last class B unit, sent after it
				push.job0.meta.last = 1'b0;
				push.job1 = mk_job(CLASS_B, UNIT_W'(UNITS - 1), 1'b1, b_gain_q,
				                   dsum_new, vsum_new);
				push.n    = 2'd2;
			end else begin
				push.n = 2'd1;
			end
		end
		if (!accept) begin
			push.n = 2'd0;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(SEGMENTS))
		else $error("segment counter out of frame range");
	a_last_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> (push.job1.meta.last && !push.job0.meta.last))
		else $error("last_of_run not on the second job of a pair");
`endif

endmodule

// File: rtl/core/swsr_queue.sv
// Four-entry job queue, front to back; up to two writes, one read per cycle.
// Depends on swsr_pkg.
module swsr_queue import swsr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output job_t   head,
	output qstat_t qstat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.job0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + QPTR_W'(1)] <= push.job1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

	assign head        = mem_q[rd_ptr_q];
	assign qstat.empty = (cnt_q == '0);
	assign qstat.room2 = (cnt_q <= QCNT_W'(QDEPTH - 2));

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("job queue overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty job queue");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> cnt_q <= QCNT_W'(QDEPTH - 2))
		else $error("push without room for a pair");
`endif

endmodule

// File: rtl/core/swsr_mean_scale.sv
// Five-stage datapath: round(sum * gain / 6), ties away from zero, saturated.
// Depends on swsr_pkg; one instance per length channel in swsr_back.
module swsr_mean_scale import swsr_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic [SUM_W-1:0]         sum,
	input  logic [GAIN_W-1:0]        gain,
	output logic signed [RESP_W-1:0] resp
);

	localparam int QS_W    = 16;
	localparam int T_W     = 18;
	localparam int SMALL_W = 15;
	localparam int BIG_W   = 32;
	localparam int P1_W    = SUM_W + RECIP_W;
	localparam int P2_W    = T_W + RECIP_W;

	// split sum = 6*qs + rs, then |gain*sum|/6 = qs*|g| + (rs*|g| + 3)/6
	logic [SUM_W-1:0]   sum_s1;
	logic [QS_W-1:0]    qs_s1;
	logic [GAIN_W-1:0]  gmag_s1, gmag_s2;
	logic               gneg_s1, gneg_s2, gneg_s3, gneg_s4;
	logic [2:0]         rs_s2;
	logic [BIG_W-1:0]   big_s2, big_s3, big_s4;
	logic [T_W-1:0]     t_s3;
	logic [SMALL_W-1:0] small_s4;

	logic [P1_W-1:0]    p1;
	logic [SUM_W-1:0]   rem;
	logic [P2_W-1:0]    p2;
	logic [BIG_W:0]     q;
	logic [RESP_W-1:0]  res;

	assign p1  = P1_W'(sum) * P1_W'(RECIP_SIX);
	assign rem = sum_s1 - SUM_W'(qs_s1) * SUM_W'(WINDOW);
	assign p2  = P2_W'(t_s3) * P2_W'(RECIP_SIX);
	assign q   = (BIG_W + 1)'(big_s4) + (BIG_W + 1)'(small_s4);

	always_comb begin
		if (gneg_s4) begin
			if (q > (BIG_W + 1)'(33'h0_8000_0000)) begin
				res = 32'h8000_0000;
			end else begin
				res = RESP_W'(~q + (BIG_W + 1)'(1));
			end
		end else if (q > (BIG_W + 1)'(33'h0_7FFF_FFFF)) begin
			res = 32'h7FFF_FFFF;
		end else begin
			res = RESP_W'(q);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1   <= sum;
			qs_s1    <= p1[RECIP_SHIFT +: QS_W];
			gneg_s1  <= gain[GAIN_W-1];
			gmag_s1  <= gain[GAIN_W-1] ? (~gain + GAIN_W'(1)) : gain;

			rs_s2    <= rem[2:0];
			big_s2   <= BIG_W'(qs_s1) * BIG_W'(gmag_s1);
			gmag_s2  <= gmag_s1;
			gneg_s2  <= gneg_s1;

			t_s3     <= T_W'(rs_s2) * T_W'(gmag_s2) + T_W'(ROUND_BIAS);
			big_s3   <= big_s2;
			gneg_s3  <= gneg_s2;

			small_s4 <= p2[RECIP_SHIFT +: SMALL_W];
			big_s4   <= big_s3;
			gneg_s4  <= gneg_s3;

			resp     <= res;
		end
	end

endmodule

// File: rtl/core/swsr_back.sv
// Back end: pops jobs, runs both channels through the scaling pipeline, output register.
// Depends on swsr_pkg and swsr_mean_scale.
module swsr_back import swsr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  job_t                     head,
	input  qstat_t                   qstat,
	output logic                     pop,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic                     receptor_class,
	output logic [UNIT_W-1:0]        unit_index,
	output logic signed [RESP_W-1:0] dorsal_response,
	output logic signed [RESP_W-1:0] ventral_response,
	output logic                     last_of_run
);

	logic  adv;
	logic  v_s1, v_s2, v_s3, v_s4, v_q;
	meta_t m_s1, m_s2, m_s3, m_s4, m_q;

	// whole pipeline moves together unless a held result blocks it
	assign adv = !v_q || !rsp_stall;
	assign pop = adv && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_q  <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_q  <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1 <= head.meta;
			m_s2 <= m_s1;
			m_s3 <= m_s2;
			m_s4 <= m_s3;
			m_q  <= m_s4;
		end
	end

	swsr_mean_scale u_dorsal (
		.clk  (clk),
		.en   (adv),
		.sum  (head.dsum),
		.gain (head.gain),
		.resp (dorsal_response)
	);

	swsr_mean_scale u_ventral (
		.clk  (clk),
		.en   (adv),
		.sum  (head.vsum),
		.gain (head.gain),
		.resp (ventral_response)
	);

	assign rsp_valid      = v_q;
	assign receptor_class = m_q.cls;
	assign unit_index     = m_q.unit;
	assign last_of_run    = m_q.last;

`ifndef ASSERT_OFF
	a_pop_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && rsp_stall) |-> !pop)
		else $error("job popped while output is held");
`endif

endmodule

// File: rtl/core/strided_window_stretch_receptor_top.sv
// Strided window stretch receptor: each segment's jobs pass the job queue and the scaling pipeline.
// Throughput: one result transfer per cycle while rsp_stall is low, set by the
// single-issue scaling pipeline behind the job queue.
// Reset (arst_n, async, low): gains to 1.0, delay lines, sums and segment count to zero,
// job queue and pipeline emptied.
// Depends on swsr_pkg, swsr_front, swsr_queue, swsr_back.
module strided_window_stretch_receptor_top import swsr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration writes: index 0 class A gain, index 1 class B gain
	input  logic                     wr_en,
	input  logic [CFG_IDX_W-1:0]     wr_index,
	input  logic [GAIN_W-1:0]        wr_data,
	// segment channel
	input  logic                     seg_valid,
	output logic                     seg_stall,
	input  logic [LEN_W-1:0]         dorsal_length,
	input  logic [LEN_W-1:0]         ventral_length,
	// result channel
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic                     receptor_class,
	output logic [UNIT_W-1:0]        unit_index,
	output logic signed [RESP_W-1:0] dorsal_response,
	output logic signed [RESP_W-1:0] ventral_response,
	output logic                     last_of_run
);

	// front -> queue: zero, one or two jobs per segment transfer
	push_t  push;
	// queue -> front/back: occupancy status
	qstat_t qstat;
	job_t   head;
	logic   pop;

	// Front: takes a segment only when the queue can hold a full pair of jobs,
	// so the result count per segment never needs to be known before transfer.
	swsr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.seg_valid      (seg_valid),
		.seg_stall      (seg_stall),
		.dorsal_length  (dorsal_length),
		.ventral_length (ventral_length),
		.qstat          (qstat),
		.push           (push)
	);

	// Queue: decouples segment intake from result delivery.
	swsr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// Back: one job per cycle through the scaling pipeline unless a held result stalls it;
	// the last stage is the output register and holds a valid result while rsp_stall is high.
	swsr_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.qstat            (qstat),
		.pop              (pop),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.receptor_class   (receptor_class),
		.unit_index       (unit_index),
		.dorsal_response  (dorsal_response),
		.ventral_response (ventral_response),
		.last_of_run      (last_of_run)
	);

endmodule

// File: verif/receptor_response_checker.sv
// Result checker for the strided window stretch receptor: follows gain writes and
// segment transfers, predicts each receptor result and compares the result channel.
// Depends on swsr_pkg.
module receptor_response_checker import swsr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [CFG_IDX_W-1:0]     wr_index,
	input  logic [GAIN_W-1:0]        wr_data,
	input  logic                     seg_valid,
	input  logic                     seg_stall,
	input  logic [LEN_W-1:0]         dorsal_length,
	input  logic [LEN_W-1:0]         ventral_length,
	input  logic                     rsp_valid,
	input  logic                     rsp_stall,
	input  logic                     receptor_class,
	input  logic [UNIT_W-1:0]        unit_index,
	input  logic signed [RESP_W-1:0] dorsal_response,
	input  logic signed [RESP_W-1:0] ventral_response,
	input  logic                     last_of_run,
	output int                       mismatch_count,
	output int                       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     REPORT_CAP = 40;
	localparam longint RESP_MAX   = 64'sd2147483647;

	typedef struct {
		rclass_t                  cls;
		logic [UNIT_W-1:0]        unit;
		logic signed [RESP_W-1:0] dorsal;
		logic signed [RESP_W-1:0] ventral;
		logic                     last;
	} receptor_result_t;

	receptor_result_t  awaited_results[$];
	logic [LEN_W-1:0]  dorsal_line [WINDOW];
	logic [LEN_W-1:0]  ventral_line [WINDOW];
	logic [CNT_W-1:0]  seg_count;
	logic [GAIN_W-1:0] gain_a;
	logic [GAIN_W-1:0] gain_b;

	initial mismatch_count = 0;

	// window sum * Q8.8 gain / 6, rounded half away from zero, saturated
	function automatic logic signed [RESP_W-1:0] scaled_mean(logic [SUM_W-1:0] sum,
			logic [GAIN_W-1:0] gain);
		longint prod, mag, quo;
		prod = longint'(sum) * longint'($signed(gain));
		mag  = (prod < 0) ? -prod : prod;
		quo  = (mag + WINDOW / 2) / WINDOW;
		if (prod < 0)
			return (quo > RESP_MAX + 1) ? RESP_W'(-RESP_MAX - 1) : RESP_W'(-quo);
		return (quo > RESP_MAX) ? RESP_W'(RESP_MAX) : RESP_W'(quo);
	endfunction

	function automatic receptor_result_t make_result(rclass_t cls, int unit,
			logic [SUM_W-1:0] dsum, logic [SUM_W-1:0] vsum, logic [GAIN_W-1:0] gain);
		receptor_result_t r;
		r.cls     = cls;
		r.unit    = UNIT_W'(unit);
		r.dorsal  = scaled_mean(dsum, gain);
		r.ventral = scaled_mean(vsum, gain);
		r.last    = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		if (mismatch_count < REPORT_CAP)
			$display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got,
				want);
		mismatch_count++;
	endtask

	task automatic predict_segment(logic [LEN_W-1:0] d, logic [LEN_W-1:0] v);
		logic [SUM_W-1:0] dsum, vsum;
		int pos, unit;
		receptor_result_t fresh[$];
		for (int i = WINDOW - 1; i > 0; i--) begin
			dorsal_line[i]  = dorsal_line[i-1];
			ventral_line[i] = ventral_line[i-1];
		end
		dorsal_line[0]  = d;
		ventral_line[0] = v;
		dsum = '0;
		vsum = '0;
		for (int i = 0; i < WINDOW; i++) begin
			dsum += dorsal_line[i];
			vsum += ventral_line[i];
		end
		pos = int'(seg_count) + 1;
		seg_count = (seg_count >= SEGMENTS - 1) ? '0 : seg_count + 1'b1;

		// class A, head unit doubles the first window
		if (pos >= A_FIRST && (pos - A_FIRST) % STRIDE == 0 && pos <= A_LAST) begin
			unit = (pos - A_FIRST) / STRIDE + 1;
			if (unit == 1)
				fresh.push_back(make_result(CLASS_A, 0, dsum, vsum, gain_a));
			fresh.push_back(make_result(CLASS_A, unit, dsum, vsum, gain_a));
		end
		// class B, tail unit doubles the last window
		if (fresh.size() < 2 && pos >= B_FIRST && (pos - B_FIRST) % STRIDE == 0 &&
				pos <= B_LAST) begin
			unit = (pos - B_FIRST) / STRIDE;
			fresh.push_back(make_result(CLASS_B, unit, dsum, vsum, gain_b));
			if (unit == UNITS - 2 && fresh.size() < 2)
				fresh.push_back(make_result(CLASS_B, UNITS - 1, dsum, vsum, gain_b));
		end
		if (fresh.size() > 0)
			fresh[fresh.size()-1].last = 1'b1;
		foreach (fresh[i])
			awaited_results.push_back(fresh[i]);
	endtask

	task automatic check_result();
		receptor_result_t want;
		if (awaited_results.size() == 0) begin
			report_mismatch("unexpected result, unit_index", unit_index, -1);
			return;
		end
		want = awaited_results.pop_front();
		if (receptor_class !== want.cls)
			report_mismatch("receptor_class", receptor_class, want.cls);
		if (unit_index !== want.unit)
			report_mismatch("unit_index", unit_index, want.unit);
		if (dorsal_response !== want.dorsal)
			report_mismatch("dorsal_response", dorsal_response, want.dorsal);
		if (ventral_response !== want.ventral)
			report_mismatch("ventral_response", ventral_response, want.ventral);
		if (last_of_run !== want.last)
			report_mismatch("last_of_run", last_of_run, want.last);
	endtask

	// results are checked before this edge's segment is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_results.delete();
			foreach (dorsal_line[i]) begin
				dorsal_line[i]  = '0;
				ventral_line[i] = '0;
			end
			seg_count = '0;
			gain_a = GAIN_RESET;
			gain_b = GAIN_RESET;
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_result();
			if (wr_en) begin
				case (wr_index)
					CFG_A_GAIN: gain_a = wr_data;
					CFG_B_GAIN: gain_b = wr_data;
					default: ;
				endcase
			end
			if (seg_valid && !seg_stall)
				predict_segment(dorsal_length, ventral_length);
			outstanding <= awaited_results.size();
		end
	end

endmodule

// File: verif/strided_window_stretch_receptor_top_tb.sv
// Testbench top for strided_window_stretch_receptor_top: clock, reset, segment stimulus,
// gain writes, result-side stalls and the verdict.
// Depends on swsr_pkg, the receptor RTL and receptor_response_checker.
module strided_window_stretch_receptor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import swsr_pkg::*;

	localparam int HALF_PERIOD    = 2;
	localparam int RESET_CYCLES   = 8;
	localparam int MAX_GAP        = 12;
	// leave margin for the job queue to empty
	localparam int DRAIN_CYCLES   = 16;
	localparam int LONG_HOLD      = 300;
	localparam int PRESSURE_ITEMS = 60;
	localparam int NUM_PHASES     = 7;
	localparam int PHASE_ITEMS    = 240;
	localparam int PRESSURE_PHASE = 2;
	localparam int GROUP_ITEMS    = 8;
	// limit set well above the slowest legal run
	localparam int CYCLE_LIMIT    = 400000;
	localparam int DIRECTED_ITEMS = 24;

	// Directed segments, counted from the first segment of a frame:
	//   1-6   full dorsal, empty ventral: head and first class A unit together
	//   7-10  dorsal drops to zero, ventral to full: mixed window at segment 10
	//   11-14 values around the sign bit and one off the extremes
	//   15-18 both full: class A and class B fire on the same segment at 18
	//   19-24 bit patterns, window end at 22 with both classes
	localparam logic [LEN_W-1:0] DIR_DORSAL [DIRECTED_ITEMS] = '{
		16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE,
		16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF, 16'h1234, 16'hEDCB};
	localparam logic [LEN_W-1:0] DIR_VENTRAL [DIRECTED_ITEMS] = '{
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		16'h7FFF, 16'h8000, 16'hFFFE, 16'h0001,
		16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		16'h5555, 16'hAAAA, 16'hFFFF, 16'h0000, 16'hEDCB, 16'h1234};

	// how a run of random segments fills its lengths
	typedef enum int {
		FILL_RANDOM,
		FILL_MAX,
		FILL_ZERO,
		FILL_EDGES
	} fill_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     wr_en;
	logic [CFG_IDX_W-1:0]     wr_index;
	logic [GAIN_W-1:0]        wr_data;
	logic                     seg_valid;
	logic                     seg_stall;
	logic [LEN_W-1:0]         dorsal_length;
	logic [LEN_W-1:0]         ventral_length;
	logic                     rsp_valid;
	logic                     rsp_stall;
	logic                     receptor_class;
	logic [UNIT_W-1:0]        unit_index;
	logic signed [RESP_W-1:0] dorsal_response;
	logic signed [RESP_W-1:0] ventral_response;
	logic                     last_of_run;
	int                       mismatch_count;
	int                       outstanding;

	// sender runs without gaps while set
	bit tx_quiet;
	// stimulus asks the result side for one long hold-off
	bit hold_req;

	always #(HALF_PERIOD) clk = ~clk;

	strided_window_stretch_receptor_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.seg_valid        (seg_valid),
		.seg_stall        (seg_stall),
		.dorsal_length    (dorsal_length),
		.ventral_length   (ventral_length),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.receptor_class   (receptor_class),
		.unit_index       (unit_index),
		.dorsal_response  (dorsal_response),
		.ventral_response (ventral_response),
		.last_of_run      (last_of_run)
	);

	receptor_response_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.seg_valid        (seg_valid),
		.seg_stall        (seg_stall),
		.dorsal_length    (dorsal_length),
		.ventral_length   (ventral_length),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.receptor_class   (receptor_class),
		.unit_index       (unit_index),
		.dorsal_response  (dorsal_response),
		.ventral_response (ventral_response),
		.last_of_run      (last_of_run),
		.mismatch_count   (mismatch_count),
		.outstanding      (outstanding)
	);

	function automatic logic [LEN_W-1:0] pick_length(fill_t fill);
		case (fill)
			FILL_RANDOM: return LEN_W'($urandom_range(0, 16'hFFFF));
			FILL_MAX:    return '1;
			FILL_ZERO:   return '0;
			default: begin
				case ($urandom_range(0, 3))
					0:       return '0;
					1:       return '1;
					2:       return 16'h8000;
					default: return LEN_W'($urandom_range(16'hFF00, 16'hFFFF));
				endcase
			end
		endcase
	endfunction

	// One segment transfer. Valid only drops when a gap is drawn, so back-to-back
	// transfers never lower and raise it in the same step.
	task automatic send_segment(logic [LEN_W-1:0] d, logic [LEN_W-1:0] v);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			seg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg_valid      <= 1'b1;
		dorsal_length  <= d;
		ventral_length <= v;
		@(posedge clk);
		while (seg_stall)
			@(posedge clk);
	endtask

	// Random segments in groups: each group picks a fill per field and, unless the
	// caller keeps the sender busy, whether this group idles at all.
	task automatic send_random_segments(int count, bit keep_busy);
		fill_t dorsal_fill, ventral_fill;
		dorsal_fill  = FILL_RANDOM;
		ventral_fill = FILL_RANDOM;
		for (int i = 0; i < count; i++) begin
			if (i % GROUP_ITEMS == 0) begin
				dorsal_fill  = fill_t'($urandom_range(0, 3));
				ventral_fill = fill_t'($urandom_range(0, 3));
				tx_quiet = keep_busy || ($urandom_range(0, 3) == 0);
			end
			send_segment(pick_length(dorsal_fill), pick_length(ventral_fill));
		end
		tx_quiet = 1'b0;
	endtask

	// Stop offering, wait for every predicted result, then let the pipeline settle
	// in case the last segments ended no window.
	task automatic drain_results();
		seg_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
	endtask

	// both gains, plus a write to an unused index that the block must ignore
	task automatic set_gains(logic [GAIN_W-1:0] a_gain, logic [GAIN_W-1:0] b_gain);
		logic [CFG_IDX_W-1:0] spare;
		do
			spare = CFG_IDX_W'($urandom);
		while (spare == CFG_A_GAIN || spare == CFG_B_GAIN);
		write_reg(CFG_A_GAIN, a_gain);
		write_reg(spare, GAIN_W'($urandom));
		write_reg(CFG_B_GAIN, b_gain);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: after each transfer draws a random stall, possibly none; every 16
	// transfers it may switch to a stretch with no stalls. On request it holds off
	// for one long stretch so the job queue fills and the segment side stalls.
	initial begin : result_sink
		int unsigned transfers, stall_len;
		bit rx_quiet;
		transfers = 0;
		rx_quiet  = 1'b0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (rsp_valid && !rsp_stall) begin
				transfers++;
				if (transfers % 16 == 0)
					rx_quiet = ($urandom_range(0, 3) == 0);
				stall_len = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
				if (stall_len != 0) begin
					rsp_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	// cycle limit: a hang anywhere ends the run as a failure
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		tx_quiet = 1'b0;
		hold_req = 1'b0;
		seg_valid      <= 1'b0;
		dorsal_length  <= '0;
		ventral_length <= '0;
		wr_en          <= 1'b0;
		wr_index       <= CFG_A_GAIN;
		wr_data        <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frame start at reset gains
		for (int k = 0; k < DIRECTED_ITEMS; k++)
			send_segment(DIR_DORSAL[k], DIR_VENTRAL[k]);

		// The segment count carries across phases, so frame wraps, tail units and
		// first windows of new frames fall under every gain setting.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase != 0) begin
				drain_results();
				case (phase)
					1:       set_gains(16'h7FFF, 16'h8000);
					2:       set_gains(16'h8000, 16'h7FFF);
					3:       set_gains(16'h0000, 16'hFFFF);
					4:       set_gains(16'hFF00, 16'h0001);
					default: set_gains(GAIN_W'($urandom), GAIN_W'($urandom));
				endcase
			end
			if (phase == PRESSURE_PHASE) begin
				// sink holds off while the sender keeps offering without gaps,
				// then the sender waits for every result before going on
				hold_req = 1'b1;
				send_random_segments(PRESSURE_ITEMS, 1'b1);
				drain_results();
			end
			send_random_segments(PHASE_ITEMS, 1'b0);
		end
		drain_results();

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/core/swsr_pkg.sv
rtl/core/swsr_front.sv
rtl/core/swsr_queue.sv
rtl/core/swsr_mean_scale.sv
rtl/core/swsr_back.sv
rtl/core/strided_window_stretch_receptor_top.sv
verif/receptor_response_checker.sv
verif/strided_window_stretch_receptor_top_tb.sv
